@@ hw/rtl/wwm_pkg.sv @@
// weekly window matcher: shared types, field widths and codes
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package wwm_pkg;

  localparam int SECS_PER_DAY = 86400;
  localparam int SEC_W        = 17;
  localparam int WDAY_W       = 3;
  localparam int MASK_W       = 7;
  localparam int SLACK_W      = 8;
  localparam int TIMER_W      = 20;
  localparam int REL_W        = 22;
  localparam int OFF_W        = 4;
  localparam int CAND_N       = 9;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(30);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RULE_ACTIVE  = 3'd0,
    CFG_DAY_MASK     = 3'd1,
    CFG_START_SECOND = 3'd2,
    CFG_END_SECOND   = 3'd3,
    CFG_TIMER_SLACK  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_NOT_SET     = 2'd0,
    ST_MATCHED     = 2'd1,
    ST_NOT_MATCHED = 2'd2,
    ST_CLEARED     = 2'd3
  } status_t;

  // one candidate day: edge day is now_days + off - 1, rel is edge minus now in seconds
  typedef struct packed {
    logic                    hit;
    logic                    matched;
    logic [OFF_W-1:0]        off;
    logic signed [REL_W-1:0] rel;
  } cand_t;

  typedef struct packed {
    logic               arm;
    logic [TIMER_W-1:0] tmin;
    logic [TIMER_W-1:0] tmax;
  } timer_t;

endpackage

@@ hw/rtl/weekly_window_matcher_unit.sv @@
// weekly window matcher top level: input register, nine day checks, pending edge, output register
// depends on wwm_pkg, wwm_day_eval, wwm_pending
`timescale 1ns / 1ps

// usage
//   in_*  : one request per transfer; tuser selects evaluate (0) or clear pending edge (1),
//           tdata carries the local time as day count, weekday, second of day, fraction flag
//   out_* : one result per request, in request order; tuser holds the status code,
//           tdata the next window edge and the timer arm with min and max seconds
//   cfg_* : register writes, one per cycle with cfg_wr_en high, only while the block is idle
// timing
//   out_tvalid rises once the request has passed the input register and the output register,
//   and one request per cycle is sustained while out_tready stays high. the nine candidate
//   days are checked side by side, combinationally, between the two registers and the pending
//   edge register is updated in the same step as the result register is loaded
// reset
//   rst_n low clears both stages, drops the pending edge and loads register defaults
//   (slack 30, everything else zero)
// stall
//   a result held by out_tready low stays stable; one more request can sit in the input
//   register behind it, after that in_tready goes low
module weekly_window_matcher_unit #(
  parameter  int DAY_BITS   = 20,
  localparam int IN_USED_W  = DAY_BITS + wwm_pkg::WDAY_W + wwm_pkg::SEC_W + 1,
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8,
  localparam int OUT_USED_W = DAY_BITS + wwm_pkg::SEC_W + 2 + 2 * wwm_pkg::TIMER_W,
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_days, now_weekday, now_second, now_fraction
  input  logic [IN_DATA_W-1:0]             in_tdata,
  // req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // edge_valid, edge_days, edge_second, timer_arm, timer_min, timer_max
  output logic [OUT_DATA_W-1:0]            out_tdata,
  // status
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [wwm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wwm_pkg::SEC_W-1:0]        cfg_wdata
);

  localparam int SW = wwm_pkg::SEC_W;
  localparam int TW = wwm_pkg::TIMER_W;

  // configuration
  logic                         rule_active_r;
  logic [wwm_pkg::MASK_W-1:0]   day_mask_r;
  logic [SW-1:0]                start_second_r;
  logic [SW-1:0]                end_second_r;
  logic [wwm_pkg::SLACK_W-1:0]  timer_slack_r;

  // input stage
  logic                         s1_valid_r;
  logic                         s1_req_r;
  logic [DAY_BITS-1:0]          s1_days_r;
  logic [wwm_pkg::WDAY_W-1:0]   s1_wday_r;
  logic [SW-1:0]                s1_sec_r;
  logic                         s1_frac_r;

  // output stage
  logic                         out_valid_r;
  wwm_pkg::status_t             status_r;
  wwm_pkg::status_t             status_nxt;
  logic                         edge_valid_r;
  logic                         edge_valid_nxt;
  logic [DAY_BITS-1:0]          edge_days_r;
  logic [DAY_BITS-1:0]          edge_days_nxt;
  logic [SW-1:0]                edge_sec_r;
  logic [SW-1:0]                edge_sec_nxt;
  logic                         arm_r;
  logic                         arm_nxt;
  logic [TW-1:0]                tmin_r;
  logic [TW-1:0]                tmin_nxt;
  logic [TW-1:0]                tmax_r;
  logic [TW-1:0]                tmax_nxt;

  logic                         advance;
  logic                         eval_ok;
  logic                         found;
  logic [wwm_pkg::WDAY_W-1:0]   wday_mod;
  wwm_pkg::cand_t               cands [wwm_pkg::CAND_N];
  wwm_pkg::cand_t               pick;
  wwm_pkg::timer_t              timer;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_active_r  <= 1'b0;
      day_mask_r     <= '0;
      start_second_r <= '0;
      end_second_r   <= '0;
      timer_slack_r  <= wwm_pkg::SLACK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        wwm_pkg::CFG_RULE_ACTIVE:  rule_active_r  <= cfg_wdata[0];
        wwm_pkg::CFG_DAY_MASK:     day_mask_r     <= cfg_wdata[wwm_pkg::MASK_W-1:0];
        wwm_pkg::CFG_START_SECOND: start_second_r <= cfg_wdata;
        wwm_pkg::CFG_END_SECOND:   end_second_r   <= cfg_wdata;
        wwm_pkg::CFG_TIMER_SLACK:  timer_slack_r  <= cfg_wdata[wwm_pkg::SLACK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r  <= in_tuser;
      s1_days_r <= in_tdata[DAY_BITS-1:0];
      s1_wday_r <= in_tdata[DAY_BITS +: wwm_pkg::WDAY_W];
      s1_sec_r  <= in_tdata[DAY_BITS + wwm_pkg::WDAY_W +: SW];
      s1_frac_r <= in_tdata[IN_USED_W-1];
    end
  end

  // weekday seven acts as monday
  assign wday_mod = (s1_wday_r == 3'd7) ? 3'd0 : s1_wday_r;

  for (genvar k = 0; k < wwm_pkg::CAND_N; k++) begin : g_day
    wwm_day_eval #(
      .OFFSET(k)
    ) u_day (
      .weekday     (wday_mod),
      .now_second  (s1_sec_r),
      .now_fraction(s1_frac_r),
      .day_mask    (day_mask_r),
      .start_second(start_second_r),
      .end_second  (end_second_r),
      .cand        (cands[k])
    );
  end

  // earliest day wins
  always_comb begin
    pick  = cands[wwm_pkg::CAND_N-1];
    found = 1'b0;
    for (int k = wwm_pkg::CAND_N - 1; k >= 0; k--) begin
      if (cands[k].hit) begin
        pick  = cands[k];
        found = 1'b1;
      end
    end
  end

  assign eval_ok       = !s1_req_r && rule_active_r && (day_mask_r != '0);
  assign edge_days_nxt = s1_days_r + DAY_BITS'(pick.off) - DAY_BITS'(1);
  assign edge_sec_nxt  = pick.matched ? end_second_r : start_second_r;

  wwm_pending #(
    .DAY_BITS(DAY_BITS)
  ) u_pending (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_i     (advance && s1_valid_r && s1_req_r),
    .update_i    (advance && s1_valid_r && eval_ok && found),
    .now_days    (s1_days_r),
    .now_second  (s1_sec_r),
    .now_fraction(s1_frac_r),
    .edge_days   (edge_days_nxt),
    .edge_second (edge_sec_nxt),
    .pick        (pick),
    .timer_slack (timer_slack_r),
    .timer       (timer)
  );

  always_comb begin
    priority if (s1_req_r) begin
      status_nxt = wwm_pkg::ST_CLEARED;
    end else if (!rule_active_r) begin
      status_nxt = wwm_pkg::ST_NOT_SET;
    end else if (day_mask_r == '0) begin
      status_nxt = wwm_pkg::ST_NOT_MATCHED;
    end else if (!found || pick.matched) begin
      status_nxt = wwm_pkg::ST_MATCHED;
    end else begin
      status_nxt = wwm_pkg::ST_NOT_MATCHED;
    end
    edge_valid_nxt = eval_ok && found;
    arm_nxt        = edge_valid_nxt && timer.arm;
    tmin_nxt       = arm_nxt ? timer.tmin : '0;
    tmax_nxt       = arm_nxt ? timer.tmax : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      status_r     <= status_nxt;
      edge_valid_r <= edge_valid_nxt;
      edge_days_r  <= edge_valid_nxt ? edge_days_nxt : '0;
      edge_sec_r   <= edge_valid_nxt ? edge_sec_nxt : '0;
      arm_r        <= arm_nxt;
      tmin_r       <= tmin_nxt;
      tmax_r       <= tmax_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_DATA_W'({tmax_r, tmin_r, arm_r, edge_sec_r, edge_days_r, edge_valid_r});

endmodule

@@ hw/rtl/wwm_day_eval.sv @@
// weekly window matcher: window check for one candidate day relative to today
// depends on wwm_pkg
`timescale 1ns / 1ps

module wwm_day_eval #(
  parameter int OFFSET = 1
) (
  input  logic [wwm_pkg::WDAY_W-1:0] weekday,
  input  logic [wwm_pkg::SEC_W-1:0]  now_second,
  input  logic                       now_fraction,
  input  logic [wwm_pkg::MASK_W-1:0] day_mask,
  input  logic [wwm_pkg::SEC_W-1:0]  start_second,
  input  logic [wwm_pkg::SEC_W-1:0]  end_second,
  output wwm_pkg::cand_t             cand
);

  localparam int RW = wwm_pkg::REL_W;
  localparam int ZW = wwm_pkg::REL_W - wwm_pkg::SEC_W;
  localparam logic signed [RW-1:0] BASE = RW'((OFFSET - 1) * wwm_pkg::SECS_PER_DAY);
  localparam logic signed [RW-1:0] DAY  = RW'(wwm_pkg::SECS_PER_DAY);
  localparam logic [4:0] WD_OFF = 5'(OFFSET + 6);

  logic [4:0]                       wd_sum;
  logic [wwm_pkg::WDAY_W-1:0]       wd_idx;
  logic                             wrap;
  logic signed [RW-1:0]             rel_s;
  logic signed [RW-1:0]             rel_e;
  logic                             hit_s;
  logic                             hit_e;

  always_comb begin
    wd_sum = {2'b00, weekday} + WD_OFF;
    if (wd_sum >= 5'd14) begin
      wd_idx = 3'(wd_sum - 5'd14);
    end else if (wd_sum >= 5'd7) begin
      wd_idx = 3'(wd_sum - 5'd7);
    end else begin
      wd_idx = 3'(wd_sum);
    end
  end

  assign wrap  = (end_second <= start_second);
  assign rel_s = BASE + $signed({{ZW{1'b0}}, start_second}) - $signed({{ZW{1'b0}}, now_second});
  assign rel_e = BASE + (wrap ? DAY : '0) + $signed({{ZW{1'b0}}, end_second})
                 - $signed({{ZW{1'b0}}, now_second});
  assign hit_s = (rel_s > 0);
  assign hit_e = (rel_e > 0) || ((rel_e == '0) && !now_fraction);

  always_comb begin
    cand.hit     = day_mask[wd_idx] && (hit_s || hit_e);
    cand.matched = !hit_s;
    cand.off     = (!hit_s && wrap) ? wwm_pkg::OFF_W'(OFFSET + 1) : wwm_pkg::OFF_W'(OFFSET);
    cand.rel     = hit_s ? rel_s : rel_e;
  end

endmodule

@@ hw/rtl/wwm_pending.sv @@
// weekly window matcher: nearest pending edge register and timer arm computation
// depends on wwm_pkg
`timescale 1ns / 1ps

module wwm_pending #(
  parameter int DAY_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear_i,
  input  logic                         update_i,
  input  logic [DAY_BITS-1:0]          now_days,
  input  logic [wwm_pkg::SEC_W-1:0]    now_second,
  input  logic                         now_fraction,
  input  logic [DAY_BITS-1:0]          edge_days,
  input  logic [wwm_pkg::SEC_W-1:0]    edge_second,
  input  wwm_pkg::cand_t               pick,
  input  logic [wwm_pkg::SLACK_W-1:0]  timer_slack,
  output wwm_pkg::timer_t              timer
);

  localparam int DW = DAY_BITS + 2;
  localparam int RW = wwm_pkg::REL_W;
  localparam int ZW = wwm_pkg::REL_W - wwm_pkg::SEC_W;
  localparam logic signed [DW-1:0] D_ONE  = DW'(1);
  localparam logic signed [DW-1:0] D_MONE = DW'(-1);
  localparam logic signed [RW-1:0] DAY    = RW'(wwm_pkg::SECS_PER_DAY);

  logic                        pend_valid_r;
  logic                        pend_valid_nxt;
  logic [DAY_BITS-1:0]         pend_days_r;
  logic [DAY_BITS-1:0]         pend_days_nxt;
  logic [wwm_pkg::SEC_W-1:0]   pend_sec_r;
  logic [wwm_pkg::SEC_W-1:0]   pend_sec_nxt;

  logic signed [DW-1:0]        d_now;
  logic signed [DW-1:0]        d_edge;
  logic                        now_ge;
  logic                        edge_lt;
  logic                        pend_live;
  logic signed [RW-1:0]        iv;
  logic [RW-1:0]               ivu;
  logic [RW-1:0]               iv_slack;

  // seconds difference for day distance of -1, 0 or +1
  function automatic logic signed [RW-1:0] sec_diff(
    input logic [1:0]                d,
    input logic [wwm_pkg::SEC_W-1:0] a,
    input logic [wwm_pkg::SEC_W-1:0] b
  );
    logic signed [RW-1:0] base;
    unique case (d)
      2'b01:   base = DAY;
      2'b11:   base = -DAY;
      default: base = '0;
    endcase
    return base + $signed({{ZW{1'b0}}, a}) - $signed({{ZW{1'b0}}, b});
  endfunction

  always_comb begin
    d_now  = $signed({2'b00, now_days}) - $signed({2'b00, pend_days_r});
    d_edge = d_now + $signed({{(DW - wwm_pkg::OFF_W){1'b0}}, pick.off}) - D_ONE;

    now_ge = (d_now > D_ONE) ||
             (!(d_now < D_MONE) && (sec_diff(d_now[1:0], now_second, pend_sec_r) >= 0));
    edge_lt = (d_edge < D_MONE) ||
              (!(d_edge > D_ONE) && (sec_diff(d_edge[1:0], edge_second, pend_sec_r) < 0));

    pend_live = pend_valid_r && !now_ge;

    iv       = pick.rel + $signed({{(RW - 1){1'b0}}, now_fraction});
    ivu      = iv[RW-1] ? '0 : RW'(iv);
    iv_slack = ivu + {{(RW - wwm_pkg::SLACK_W){1'b0}}, timer_slack};

    timer.arm  = !pend_live || edge_lt;
    timer.tmin = ivu[wwm_pkg::TIMER_W-1:0];
    timer.tmax = iv_slack[wwm_pkg::TIMER_W-1:0];
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_days_nxt  = pend_days_r;
    pend_sec_nxt   = pend_sec_r;
    priority if (clear_i) begin
      pend_valid_nxt = 1'b0;
    end else if (update_i && timer.arm) begin
      pend_valid_nxt = 1'b1;
      pend_days_nxt  = edge_days;
      pend_sec_nxt   = edge_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_days_r  <= '0;
      pend_sec_r   <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_days_r  <= pend_days_nxt;
      pend_sec_r   <= pend_sec_nxt;
    end
  end

endmodule

@@ test/weekly_window_matcher_unit_tb.sv @@
// self-checking testbench for weekly_window_matcher_unit: directed and random requests
// over several register settings, with randomized stalls on both stream sides
// depends on wwm_pkg and the weekly_window_matcher_unit rtl
`timescale 1ns / 1ps

module weekly_window_matcher_unit_tb;

  localparam int DAY_W     = 20;
  localparam int SEC_BITS  = wwm_pkg::SEC_W;
  localparam int WDAY_BITS = wwm_pkg::WDAY_W;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 80;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic                       clear;
    logic [DAY_W-1:0]           now_days;
    logic [wwm_pkg::WDAY_W-1:0] now_wday;
    logic [wwm_pkg::SEC_W-1:0]  now_sec;
    logic                       now_frac;
  } time_req_t;

  typedef struct packed {
    wwm_pkg::status_t            status;
    logic                        edge_valid;
    logic [DAY_W-1:0]            edge_days;
    logic [wwm_pkg::SEC_W-1:0]   edge_sec;
    logic                        arm;
    logic [wwm_pkg::TIMER_W-1:0] tmin;
    logic [wwm_pkg::TIMER_W-1:0] tmax;
  } match_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic [1:0]        out_tuser;
  logic              cfg_wr_en = 1'b0;
  logic [wwm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [wwm_pkg::SEC_W-1:0]  cfg_wdata = '0;

  // register copy and pending edge of the predictor
  logic                        cfg_rule = 1'b0;
  logic [wwm_pkg::MASK_W-1:0]  cfg_mask = '0;
  logic [wwm_pkg::SEC_W-1:0]   cfg_start = '0;
  logic [wwm_pkg::SEC_W-1:0]   cfg_end = '0;
  logic [wwm_pkg::SLACK_W-1:0] cfg_slack = wwm_pkg::SLACK_RESET;
  logic                        pend_valid = 1'b0;
  logic [DAY_W-1:0]            pend_days = '0;
  logic [wwm_pkg::SEC_W-1:0]   pend_sec = '0;

  time_req_t     request_q[$];
  match_result_t window_results_q[$];
  time_req_t     cur_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_go = 0;
  bit long_hold_used = 0;
  int hold_cnt = 0;
  int submitted = 0;
  int results_seen = 0;
  int errors = 0;
  int n_settings = 0;
  int n_matched = 0, n_unmatched = 0, n_cleared = 0, n_not_set = 0, n_arms = 0;
  int cycle_cnt = 0;

  // stimulus cursor that walks through local time
  logic [DAY_W-1:0]  cur_days = '0;
  int                cur_wday = 0;
  int                cur_sec = 0;

  weekly_window_matcher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic match_result_t evaluate_window(time_req_t r);
    match_result_t res;
    longint nd, ns, fr, from, st, en, sday, eday, s_abs, en_abs;
    longint e_day, e_sec, e_abs, p_abs, iv, tm;
    int id;
    bit found, matched;
    res = '0;
    found = 0;
    matched = 0;
    e_day = 0;
    e_sec = 0;
    e_abs = 0;
    nd = r.now_days;
    ns = r.now_sec;
    fr = r.now_frac;
    st = cfg_start;
    en = cfg_end;
    from = nd * wwm_pkg::SECS_PER_DAY + ns;
    if (r.clear) begin
      pend_valid = 1'b0;
      res.status = wwm_pkg::ST_CLEARED;
      return res;
    end
    if (!cfg_rule) begin
      res.status = wwm_pkg::ST_NOT_SET;
      return res;
    end
    if (cfg_mask == '0) begin
      res.status = wwm_pkg::ST_NOT_MATCHED;
      return res;
    end
    for (int i = -1; i < 8 && !found; i++) begin
      id = (int'(r.now_wday) + i + 7) % 7;
      if (cfg_mask[id]) begin
        sday = nd + i;
        s_abs = sday * wwm_pkg::SECS_PER_DAY + st;
        eday = sday + ((en <= st) ? 1 : 0);
        en_abs = eday * wwm_pkg::SECS_PER_DAY + en;
        if (s_abs > from) begin
          found = 1;
          matched = 0;
          e_day = sday;
          e_sec = st;
          e_abs = s_abs;
        end else if (en_abs > from || (en_abs == from && fr == 0)) begin
          found = 1;
          matched = 1;
          e_day = eday;
          e_sec = en;
          e_abs = en_abs;
        end
      end
    end
    if (!found) begin
      res.status = wwm_pkg::ST_MATCHED;
      return res;
    end
    res.status = matched ? wwm_pkg::ST_MATCHED : wwm_pkg::ST_NOT_MATCHED;
    res.edge_valid = 1'b1;
    res.edge_days = e_day[DAY_W-1:0];
    res.edge_sec = e_sec[wwm_pkg::SEC_W-1:0];
    p_abs = longint'(pend_days) * wwm_pkg::SECS_PER_DAY + longint'(pend_sec);
    if (pend_valid && from >= p_abs) pend_valid = 1'b0;
    if (!pend_valid || e_abs < p_abs) begin
      iv = e_abs - from + fr;
      if (iv < 0) iv = 0;
      tm = iv + longint'(cfg_slack);
      pend_valid = 1'b1;
      pend_days = e_day[DAY_W-1:0];
      pend_sec = e_sec[wwm_pkg::SEC_W-1:0];
      res.arm = 1'b1;
      res.tmin = iv[wwm_pkg::TIMER_W-1:0];
      res.tmax = tm[wwm_pkg::TIMER_W-1:0];
    end
    return res;
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) window_results_q.push_back(evaluate_window(cur_req));
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, cur_req.now_frac, cur_req.now_sec, cur_req.now_wday,
                       cur_req.now_days};
          in_tuser <= cur_req.clear;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (long_hold_go && !long_hold_used) begin
      long_hold_used = 1;
      hold_cnt = 80;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    match_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (window_results_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
      end else begin
        w = window_results_q.pop_front();
        check_field("status", w.status, out_tuser);
        check_field("edge_valid", w.edge_valid, out_tdata[0]);
        check_field("edge_days", w.edge_days, out_tdata[20:1]);
        check_field("edge_second", w.edge_sec, out_tdata[37:21]);
        check_field("timer_arm", w.arm, out_tdata[38]);
        check_field("timer_min", w.tmin, out_tdata[58:39]);
        check_field("timer_max", w.tmax, out_tdata[78:59]);
        case (w.status)
          wwm_pkg::ST_MATCHED:     n_matched++;
          wwm_pkg::ST_NOT_MATCHED: n_unmatched++;
          wwm_pkg::ST_CLEARED:     n_cleared++;
          default:                 n_not_set++;
        endcase
        if (w.arm) n_arms++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycle_cnt, results_seen,
               submitted);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_eval(logic [DAY_W-1:0] d, int wd, int s, bit f);
    time_req_t r;
    r.clear = 1'b0;
    r.now_days = d;
    r.now_wday = wd[wwm_pkg::WDAY_W-1:0];
    r.now_sec = s[wwm_pkg::SEC_W-1:0];
    r.now_frac = f;
    request_q.push_back(r);
    submitted++;
  endtask

  task automatic add_clear();
    time_req_t r;
    r = '0;
    r.clear = 1'b1;
    r.now_days = DAY_W'($urandom);
    r.now_sec = SEC_BITS'($urandom);
    r.now_wday = WDAY_BITS'($urandom);
    r.now_frac = 1'($urandom);
    request_q.push_back(r);
    submitted++;
  endtask

  task automatic wait_drained();
    while (results_seen != submitted) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(wwm_pkg::cfg_idx_t idx, logic [wwm_pkg::SEC_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      wwm_pkg::CFG_RULE_ACTIVE:  cfg_rule = val[0];
      wwm_pkg::CFG_DAY_MASK:     cfg_mask = val[wwm_pkg::MASK_W-1:0];
      wwm_pkg::CFG_START_SECOND: cfg_start = val;
      wwm_pkg::CFG_END_SECOND:   cfg_end = val;
      wwm_pkg::CFG_TIMER_SLACK:  cfg_slack = val[wwm_pkg::SLACK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setting(bit rule, int mask, int st, int en, int slack);
    wait_drained();
    write_reg(wwm_pkg::CFG_RULE_ACTIVE, SEC_BITS'(rule));
    write_reg(wwm_pkg::CFG_DAY_MASK, SEC_BITS'(mask));
    write_reg(wwm_pkg::CFG_START_SECOND, SEC_BITS'(st));
    write_reg(wwm_pkg::CFG_END_SECOND, SEC_BITS'(en));
    write_reg(wwm_pkg::CFG_TIMER_SLACK, SEC_BITS'(slack));
    n_settings++;
  endtask

  function automatic int pick_second();
    case ($urandom_range(9))
      0: return 0;
      1: return 86399;
      2: return $urandom_range(131071);
      default: return $urandom_range(86399);
    endcase
  endfunction

  task automatic random_setting();
    int mask, st, en, slack;
    case ($urandom_range(7))
      0: mask = 0;
      1, 2: mask = 7'h7f;
      3, 4: mask = 1 << $urandom_range(6);
      default: mask = $urandom_range(127);
    endcase
    st = pick_second();
    case ($urandom_range(5))
      0: en = st;
      1: en = (st + $urandom_range(7200)) % 86400;
      default: en = pick_second();
    endcase
    case ($urandom_range(3))
      0: slack = 0;
      1: slack = 255;
      default: slack = $urandom_range(255);
    endcase
    apply_setting($urandom_range(9) != 0, mask, st, en, slack);
  endtask

  task automatic restart_cursor();
    cur_days = ($urandom_range(3) == 0) ? DAY_W'(20'hFFFFF - $urandom_range(9)) :
               DAY_W'($urandom);
    cur_wday = $urandom_range(6);
    cur_sec = $urandom_range(86399);
  endtask

  // mostly a consistent walk through time around the window edges
  task automatic add_random_item();
    int r, near;
    r = $urandom_range(99);
    if (r < 8) begin
      add_clear();
    end else if (r < 18) begin
      add_eval(DAY_W'($urandom), $urandom_range(7), $urandom_range(131071),
               1'($urandom_range(1)));
    end else begin
      case ($urandom_range(9))
        0: restart_cursor();
        1, 2: cur_sec += $urandom_range(3);
        3, 4: begin
          near = int'(cfg_start) - 2 + $urandom_range(4);
          cur_sec = (near < 0) ? 0 : near % 86400;
        end
        5, 6: begin
          near = int'(cfg_end) - 2 + $urandom_range(4);
          cur_sec = (near < 0) ? 0 : near % 86400;
        end
        7: cur_sec += $urandom_range(86400);
        default: cur_sec += $urandom_range(3600);
      endcase
      while (cur_sec >= 86400) begin
        cur_sec -= 86400;
        cur_days = cur_days + 1'b1;
        cur_wday = (cur_wday + 1) % 7;
      end
      add_eval(cur_days, cur_wday, cur_sec, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 56;

    // reset settings: not set
    add_eval(0, 0, 0, 0);
    add_eval(20'hFFFFF, 7, 131071, 1);
    add_clear();

    // empty day mask
    apply_setting(1, 0, 3600, 7200, 30);
    add_eval(100, 2, 5000, 0);
    add_eval(20'hFFFFF, 6, 86399, 1);

    // plain window, exact start and end
    apply_setting(1, 7'h7f, 3600, 7200, 0);
    add_eval(100, 2, 0, 0);
    add_eval(100, 2, 3600, 0);
    add_eval(100, 2, 7200, 0);
    add_eval(100, 2, 7200, 1);
    add_eval(100, 2, 5000, 0);
    add_clear();
    add_eval(100, 2, 5000, 1);

    // window over midnight, monday only, day count wrap, weekday seven
    apply_setting(1, 7'h01, 79200, 3600, 255);
    add_eval(200, 1, 1800, 0);
    add_eval(20'hFFFFF, 6, 80000, 1);
    add_eval(50, 7, 100, 0);
    add_eval(50, 0, 3600, 1);

    // whole-day window on sunday
    apply_setting(1, 7'h40, 0, 0, 0);
    add_eval(300, 6, 0, 0);
    add_eval(300, 5, 86399, 1);
    add_eval(300, 6, 43200, 0);

    // last second of day, then a start beyond one day
    apply_setting(1, 7'h7f, 86399, 86399, 255);
    add_eval(400, 3, 86399, 0);
    add_eval(400, 3, 86399, 1);
    apply_setting(1, 7'h7f, 131071, 100, 8);
    add_eval(0, 0, 0, 0);
    add_eval(0, 0, 131071, 1);

    for (int ph = 0; ph < 6; ph++) begin
      random_setting();
      restart_cursor();
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 56 : 0;
      recv_idle_pct = (ph < 2) ? 56 : (ph < 4) ? 16 : 0;
      if (ph == 4) long_hold_go = 1;
      for (int k = 0; k < 150; k++) add_random_item();
    end

    wait_drained();
    if (window_results_q.size() != 0) begin
      $error("%0d expected results never arrived", window_results_q.size());
      errors++;
    end
    $display("%0d requests over %0d register settings, %0d timer arms", submitted, n_settings,
             n_arms);
    $display("status counts: matched %0d, not matched %0d, cleared %0d, not set %0d",
             n_matched, n_unmatched, n_cleared, n_not_set);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
